[design/direct_mapped_writeback_cache_tags_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the cache tag core
// Immediate-consequence and next-cycle property checks, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_TAGS_CORE_MACROS_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_TAGS_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DMWC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DMWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/dmwc_pkg.sv]
// ----------------------------------------------------------------------------
// dmwc_pkg
// Shared widths, result codes and the statistics structs of the cache tag core.
// ----------------------------------------------------------------------------
package dmwc_pkg;

  localparam int ADDR_W = 32;
  localparam int VTAG_W = 22;
  localparam int CNT_W  = 32;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [1:0] {
    OUTC_READ_HIT   = 2'd0,
    OUTC_READ_MISS  = 2'd1,
    OUTC_WRITE_DONE = 2'd2
  } outcome_t;

  // One finished access, as seen by the statistics counters.
  typedef struct packed {
    logic fire;
    logic is_write;
    logic hit;
  } stat_evt_t;

  typedef struct packed {
    logic [CNT_W-1:0] reads;
    logic [CNT_W-1:0] writes;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] requests;
  } stat_cnt_t;

endpackage

[design/dmwc_if.sv]
// ----------------------------------------------------------------------------
// dmwc_in_if / dmwc_out_if
// Valid/ready channels for cache accesses and their results.
// ----------------------------------------------------------------------------
interface dmwc_in_if;
  logic                        valid;
  logic                        ready;
  logic [dmwc_pkg::ADDR_W-1:0] address;
  logic                        opcode;

  modport source (output valid, output address, output opcode, input ready);
  modport sink   (input valid, input address, input opcode, output ready);
endinterface

interface dmwc_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  outcome;
  logic                        writeback;
  logic [dmwc_pkg::VTAG_W-1:0] victim_tag;
  logic [dmwc_pkg::CNT_W-1:0]  read_count;
  logic [dmwc_pkg::CNT_W-1:0]  write_count;
  logic [dmwc_pkg::CNT_W-1:0]  hit_count;
  logic [dmwc_pkg::CNT_W-1:0]  miss_count;
  logic [dmwc_pkg::CNT_W-1:0]  request_count;

  modport source (output valid, output outcome, output writeback, output victim_tag,
                  output read_count, output write_count, output hit_count,
                  output miss_count, output request_count, input ready);
  modport sink   (input valid, input outcome, input writeback, input victim_tag,
                  input read_count, input write_count, input hit_count,
                  input miss_count, input request_count, output ready);
endinterface

[design/direct_mapped_writeback_cache_tags_core.sv]
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache_tags_core
// Tag store of a direct-mapped, write-back, write-allocate cache.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one access (address, opcode) per transfer; out_ch returns
//   exactly one result per access: outcome, write-back flag with victim tag,
//   and the five saturating counters as they stand after that access.
//   Each line keeps valid, dirty and tag in one synchronous RAM word.
//   An access steps through index reduction (quotient registered on the
//   input transfer, corrected in S_INDEX), the RAM read (S_INDEX) and the
//   read-modify-write commit (S_LOOK), which loads the result register.
//   A new access is taken only after the previous one has committed.
//   After reset the block sweeps every RAM line to clear valid and
//   dirty bits; in_ch.ready stays low during that sweep.
//   The result register lets the next access enter while a result waits.
//   If out_ch stalls, the commit waits with its read data held, and no
//   further access is taken until the result register frees up.
// ----------------------------------------------------------------------------
`include "direct_mapped_writeback_cache_tags_core_macros.svh"

module direct_mapped_writeback_cache_tags_core #(
  parameter int LINES       = 64,
  parameter int OFFSET_BITS = 4,
  parameter int INDEX_BITS  = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  dmwc_in_if.sink           in_ch,
  dmwc_out_if.source        out_ch
);
  import dmwc_pkg::*;

  localparam int IDX_W   = $clog2(LINES);
  localparam int TAG_W   = ADDR_W - OFFSET_BITS - INDEX_BITS;
  localparam int ENTRY_W = TAG_W + 2;
  localparam int VW      = (TAG_W < VTAG_W) ? TAG_W : VTAG_W;
  localparam int MOD_W   = INDEX_BITS + 17;
  localparam int RECIP   = (1 << INDEX_BITS) / LINES;
  localparam logic [INDEX_BITS:0] RECIP_V = RECIP[INDEX_BITS:0];
  localparam logic [MOD_W-1:0]    LINES_M = MOD_W'(LINES);
  localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(LINES - 1);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_INDEX = 4'b0100,
    S_LOOK  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]        clr_cnt_r;
  logic [ADDR_W-1:0]       addr_r;
  logic                    op_r;
  logic [INDEX_BITS-1:0]   quot_r;
  logic [IDX_W-1:0]        idx_r;

  logic                    in_xfer;
  logic                    commit;

  // Index reduction modulo LINES: reciprocal estimate, then one correction.
  logic [INDEX_BITS-1:0]   in_field;
  logic [2*INDEX_BITS:0]   quot_prod;
  logic [MOD_W-1:0]        prod2;
  logic [MOD_W-1:0]        rem;
  logic [MOD_W-1:0]        rem_fix;
  logic [IDX_W-1:0]        idx_nxt;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [ENTRY_W-1:0]      ram_wdata;
  logic                    ram_re;
  logic [ENTRY_W-1:0]      ram_rdata;

  logic                    rd_valid;
  logic                    rd_dirty;
  logic [TAG_W-1:0]        rd_tag;
  logic [TAG_W-1:0]        tag_in;
  logic                    hit;
  logic                    wb;
  logic                    new_dirty;
  outcome_t                outcome;

  stat_evt_t               evt;
  stat_cnt_t               cnt_nxt;

  logic                    out_valid_r;
  outcome_t                out_outcome_r;
  logic                    out_wb_r;
  logic [VTAG_W-1:0]       out_victim_r;
  stat_cnt_t               out_cnt_r;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign commit      = (state_r == S_LOOK) && (!out_valid_r || out_ch.ready);

  assign in_field  = in_ch.address[OFFSET_BITS +: INDEX_BITS];
  assign quot_prod = (2*INDEX_BITS+1)'(in_field) * RECIP_V;
  assign prod2     = MOD_W'(quot_r) * LINES_M;
  assign rem       = MOD_W'(addr_r[OFFSET_BITS +: INDEX_BITS]) - prod2;
  assign rem_fix   = (rem >= LINES_M) ? rem - LINES_M : rem;
  assign idx_nxt   = rem_fix[IDX_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_cnt_r == LAST_IDX) state_nxt = S_IDLE;
      S_IDLE:  if (in_xfer) state_nxt = S_INDEX;
      S_INDEX: state_nxt = S_LOOK;
      S_LOOK:  if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      addr_r <= in_ch.address;
      op_r   <= in_ch.opcode;
      quot_r <= quot_prod[2*INDEX_BITS-1:INDEX_BITS];
    end
    if (state_r == S_INDEX) begin
      idx_r <= idx_nxt;
    end
  end

  // Lookup and read-modify-write of the addressed line.
  assign rd_valid  = ram_rdata[ENTRY_W-1];
  assign rd_dirty  = ram_rdata[ENTRY_W-2];
  assign rd_tag    = ram_rdata[TAG_W-1:0];
  assign tag_in    = addr_r[ADDR_W-1 -: TAG_W];
  assign hit       = rd_valid && (rd_tag == tag_in);
  assign wb        = !hit && rd_valid && rd_dirty;
  assign new_dirty = (op_r == OP_WRITE) || (hit && rd_dirty);

  always_comb begin
    if (op_r == OP_WRITE) begin
      outcome = OUTC_WRITE_DONE;
    end else if (hit) begin
      outcome = OUTC_READ_HIT;
    end else begin
      outcome = OUTC_READ_MISS;
    end
  end

  assign ram_re = (state_r == S_INDEX);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = {1'b1, new_dirty, tag_in};
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if (commit) begin
      ram_we = 1'b1;
    end
  end

  dmwc_tag_ram #(
    .DEPTH (LINES),
    .AW    (IDX_W),
    .DW    (ENTRY_W)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_nxt),
    .rdata (ram_rdata)
  );

  assign evt.fire     = commit;
  assign evt.is_write = (op_r == OP_WRITE);
  assign evt.hit      = hit;

  dmwc_stats u_stats (
    .clk     (clk),
    .rst_n   (rst_n),
    .evt     (evt),
    .cnt_nxt (cnt_nxt)
  );

  // Result register: load on commit, drop on transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_outcome_r <= outcome;
      out_wb_r      <= wb;
      out_victim_r  <= wb ? VTAG_W'(rd_tag[VW-1:0]) : '0;
      out_cnt_r     <= cnt_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.outcome       = out_outcome_r;
  assign out_ch.writeback     = out_wb_r;
  assign out_ch.victim_tag    = out_victim_r;
  assign out_ch.read_count    = out_cnt_r.reads;
  assign out_ch.write_count   = out_cnt_r.writes;
  assign out_ch.hit_count     = out_cnt_r.hits;
  assign out_ch.miss_count    = out_cnt_r.misses;
  assign out_ch.request_count = out_cnt_r.requests;

  `DMWC_ASSERT_NOW(a_rw_excl, clk, rst_n, ram_re, !ram_we, "RAM read and write in one cycle")
  `DMWC_ASSERT_NEXT(a_commit_out, clk, rst_n, commit, out_valid_r, "commit lost its result")
  `DMWC_ASSERT_NOW(a_hit_no_wb, clk, rst_n, out_valid_r && out_wb_r,
                   out_outcome_r != OUTC_READ_HIT, "write-back reported on a read hit")
  `DMWC_ASSERT_NOW(a_idx_range, clk, rst_n, state_r == S_INDEX, rem_fix < LINES_M,
                   "line index out of range")
  `DMWC_ASSERT_NEXT(a_stall_hold, clk, rst_n, state_r == S_LOOK && !commit,
                    state_r == S_LOOK && $stable(ram_rdata), "stalled lookup lost read data")

endmodule

[design/dmwc_tag_ram.sv]
// ----------------------------------------------------------------------------
// dmwc_tag_ram
// Single-port-write, single-port-read line store with a registered read.
// ----------------------------------------------------------------------------
module dmwc_tag_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold the last read word until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/dmwc_stats.sv]
// ----------------------------------------------------------------------------
// dmwc_stats
// Saturating read, write, hit, miss and request counters.
// ----------------------------------------------------------------------------
module dmwc_stats (
  input  logic                clk,
  input  logic                rst_n,
  input  dmwc_pkg::stat_evt_t evt,
  output dmwc_pkg::stat_cnt_t cnt_nxt
);
  import dmwc_pkg::*;

  stat_cnt_t cnt_r;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + CNT_W'(1);
  endfunction

  always_comb begin
    cnt_nxt          = cnt_r;
    cnt_nxt.requests = sat_inc(cnt_r.requests);
    if (evt.is_write) begin
      cnt_nxt.writes = sat_inc(cnt_r.writes);
    end else begin
      cnt_nxt.reads = sat_inc(cnt_r.reads);
      if (evt.hit) begin
        cnt_nxt.hits = sat_inc(cnt_r.hits);
      end else begin
        cnt_nxt.misses = sat_inc(cnt_r.misses);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (evt.fire) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[verif/direct_mapped_writeback_cache_tags_core_test.sv]
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache_tags_core_test
// Self-checking bench for the cache tag core. A behavioral copy of the tag
// store predicts outcome, write-back, victim tag and counters for every
// accepted access; results are checked in order as they drain. Directed
// tests cover cold misses, hits, dirty evictions, address extremes, same-line
// bursts, then random traffic on a small tag pool per index deepens conflicts.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_cache_tags_core_test;
  import dmwc_pkg::*;

  localparam int LINES       = 64;
  localparam int OFFSET_BITS = 4;
  localparam int INDEX_BITS  = 6;
  localparam int STUCK_LIMIT = 2000;
  localparam int DRAIN_TAIL  = 8;

  typedef struct {
    outcome_t          outcome;
    logic              writeback;
    logic [VTAG_W-1:0] victim_tag;
    stat_cnt_t         counts;
  } access_result_t;

  logic clk;
  logic rst_n;

  dmwc_in_if  in_ch ();
  dmwc_out_if out_ch ();

  direct_mapped_writeback_cache_tags_core #(
    .LINES       (LINES),
    .OFFSET_BITS (OFFSET_BITS),
    .INDEX_BITS  (INDEX_BITS)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow tag store
  logic              shadow_valid [LINES];
  logic              shadow_dirty [LINES];
  logic [VTAG_W-1:0] shadow_tag   [LINES];
  stat_cnt_t         shadow_counts;

  access_result_t pending_results [$];
  int             error_count;
  bit             steady;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [CNT_W-1:0] sat_bump(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void clear_shadow();
    for (int i = 0; i < LINES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_dirty[i] = 1'b0;
      shadow_tag[i]   = '0;
    end
    shadow_counts = '0;
  endfunction

  function automatic access_result_t predict_access(input logic [ADDR_W-1:0] addr,
                                                    input logic op);
    access_result_t    res;
    int                idx;
    logic [VTAG_W-1:0] tag;
    logic              hit;
    idx = int'(addr[OFFSET_BITS +: INDEX_BITS]) % LINES;
    tag = addr[ADDR_W-1 -: VTAG_W];
    hit = shadow_valid[idx] && (shadow_tag[idx] == tag);
    res.writeback  = 1'b0;
    res.victim_tag = '0;
    if (!hit) begin
      if (shadow_valid[idx] && shadow_dirty[idx]) begin
        res.writeback  = 1'b1;
        res.victim_tag = shadow_tag[idx];
      end
      // refill leaves the line clean, whatever the opcode
      shadow_valid[idx] = 1'b1;
      shadow_tag[idx]   = tag;
      shadow_dirty[idx] = 1'b0;
    end
    shadow_counts.requests = sat_bump(shadow_counts.requests);
    if (op == OP_WRITE) begin
      shadow_counts.writes = sat_bump(shadow_counts.writes);
      shadow_dirty[idx]    = 1'b1;
      res.outcome          = OUTC_WRITE_DONE;
    end else begin
      shadow_counts.reads = sat_bump(shadow_counts.reads);
      if (hit) begin
        shadow_counts.hits = sat_bump(shadow_counts.hits);
        res.outcome        = OUTC_READ_HIT;
      end else begin
        shadow_counts.misses = sat_bump(shadow_counts.misses);
        res.outcome          = OUTC_READ_MISS;
      end
    end
    res.counts = shadow_counts;
    return res;
  endfunction

  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, 10);
  endfunction

  // Hold valid across back-to-back transfers; drop it only ahead of a gap.
  task automatic send_access(input logic [ADDR_W-1:0] addr, input logic op);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.address <= addr;
    in_ch.opcode  <= op;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.insert(pending_results.size(), predict_access(addr, op));
  endtask

  task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  task automatic check_result();
    access_result_t want;
    if (pending_results.size() == 0) begin
      $error("result transfer with no access outstanding");
      error_count++;
    end else begin
      want = pending_results.pop_front();
      check_field("outcome", CNT_W'(want.outcome), CNT_W'(out_ch.outcome));
      check_field("writeback", CNT_W'(want.writeback), CNT_W'(out_ch.writeback));
      check_field("victim_tag", CNT_W'(want.victim_tag), CNT_W'(out_ch.victim_tag));
      check_field("read_count", want.counts.reads, out_ch.read_count);
      check_field("write_count", want.counts.writes, out_ch.write_count);
      check_field("hit_count", want.counts.hits, out_ch.hit_count);
      check_field("miss_count", want.counts.misses, out_ch.miss_count);
      check_field("request_count", want.counts.requests, out_ch.request_count);
    end
  endtask

  // Result sink with random back-pressure
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      check_result();
    end
  end

  // End the run when no transfer happens for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle = 0;
      else
        idle++;
    end
    $display("Regression FAIL");
    $finish;
  end

  task automatic test_cold_and_hit();
    send_access(32'h0000_1230, OP_READ);   // miss on an empty line
    send_access(32'h0000_123C, OP_READ);   // hit, other offset
    send_access(32'h0000_1234, OP_WRITE);  // write hit marks dirty
    send_access(32'h0000_1230, OP_READ);
  endtask

  task automatic test_dirty_evictions();
    send_access(32'h0000_5230, OP_READ);   // read miss evicts dirty tag
    send_access(32'h0000_9230, OP_WRITE);  // line clean after read refill
    send_access(32'h0000_D230, OP_WRITE);  // write miss evicts dirty tag
    send_access(32'h0000_D230, OP_READ);
  endtask

  task automatic test_address_extremes();
    send_access(32'h0000_0000, OP_READ);
    send_access(32'hFFFF_FFFF, OP_WRITE);
    send_access(32'hFFFF_FFF0, OP_READ);
    send_access(32'h0000_03F0, OP_READ);   // victim tag all ones
    send_access(32'h0000_000F, OP_WRITE);
    send_access(32'hFFFF_FC00, OP_WRITE);  // victim tag zero
    send_access(32'hFFFF_FC00, OP_READ);
  endtask

  // Back-to-back accesses to one line exercise its read-modify-write
  task automatic test_same_line_bursts();
    steady = 1'b1;
    send_access(32'h0000_0470, OP_WRITE);
    send_access(32'h0000_0470, OP_READ);
    send_access(32'h0000_0870, OP_WRITE);
    send_access(32'h0000_0470, OP_READ);
    send_access(32'h0000_0870, OP_READ);
    send_access(32'h0000_0874, OP_WRITE);
    send_access(32'h0000_0C70, OP_READ);
    steady = 1'b0;
  endtask

  // Mostly a few tags per index so lines get hit, dirtied and evicted;
  // the rest is fully random addresses.
  task automatic test_random_traffic();
    logic [VTAG_W-1:0] tags [4];
    logic [ADDR_W-1:0] addr;
    tags[0] = '0;
    tags[1] = '1;
    for (int blk = 0; blk < 12; blk++) begin
      steady  = ($urandom_range(0, 3) == 0);
      tags[2] = VTAG_W'($urandom);
      tags[3] = VTAG_W'($urandom);
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 9) == 0)
          addr = $urandom;
        else
          addr = {tags[$urandom_range(0, 3)], 6'($urandom_range(0, 63)), 4'($urandom)};
        send_access(addr, 1'($urandom_range(0, 1)));
      end
    end
    steady = 1'b0;
  endtask

  initial begin : main_flow
    error_count = 0;
    steady      = 1'b0;
    clear_shadow();
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.address <= '0;
    in_ch.opcode  <= OP_READ;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_cold_and_hit();
    test_dirty_evictions();
    test_address_extremes();
    test_same_line_bursts();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/dmwc_pkg.sv
design/dmwc_if.sv
design/dmwc_tag_ram.sv
design/dmwc_stats.sv
design/direct_mapped_writeback_cache_tags_core.sv
verif/direct_mapped_writeback_cache_tags_core_test.sv
